// ----- hdl/smpq_pkg.sv -----
// Shared types, sizes and codes of the sorted max-priority queue.
package smpq_pkg;

    localparam int DEPTH       = 32;
    localparam int DATA_WIDTH  = 32;
    localparam int PRIO_WIDTH  = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CAP_W       = 6;
    localparam int FIELD_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 6;
    localparam int S_DATA_W    = 64;
    localparam int M_DATA_W    = 80;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic capture;
        logic execute;
    } smpq_cmd_t;

endpackage

// ----- hdl/sorted_max_priority_queue.sv -----
// Top level of the sorted max-priority queue.
//
// Usage: each input transfer on the s_ channel is one operation. s_tuser
// selects it: enqueue carries a value and a priority in s_tdata, dequeue
// ignores s_tdata. Every operation gives exactly one result transfer on the
// m_ channel with a status, the removed pair on a successful dequeue, and
// the count with the empty and full flags after the operation.
// Entries sit in a row of cells sorted by descending priority; an enqueue
// lands after every entry of equal or higher priority, so ties leave in
// arrival order. Enqueue when full and dequeue when empty change nothing.
// Timing: an item is captured into the operand registers at its accepting
// edge, the controller enters execute, and the cell row and result register
// update, raising m_tvalid, at the edge on which it fires. A new item is not
// taken until the last one fires, as the controller sequences capture then update.
// While a result waits for m_tready the next item is still accepted and
// captured; its update then waits until the result register drains.
// Reset (aresetn low at a clock edge) empties the queue and sets the
// capacity to 32; no clearing pass follows. cfg_we writes the capacity and
// is meant only while the queue is idle.
module sorted_max_priority_queue
    import smpq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // value [31:0], priority_req [63:32]
    input  logic [S_DATA_W-1:0]  s_tdata,
    // mode [0]
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status [1:0], out_value [33:2], out_priority [65:34], count [71:66],
    // is_empty [72], is_full [73], zero [79:74]
    output logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_we,
    input  logic [CAP_W-1:0]     cfg_wdata
);

    // Commands from the controller to the datapath.
    smpq_cmd_t cmd;

    logic [STATUS_W-1:0]    res_status;
    logic [FIELD_W-1:0]     res_value;
    logic [FIELD_W-1:0]     res_priority;
    logic [COUNT_OUT_W-1:0] res_count;
    logic                   res_empty;
    logic                   res_full;

    // The controller owns both handshakes and the result valid flag.
    smpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath holds the cells, the count, the capacity and the result.
    smpq_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .in_mode      (s_tuser[0]),
        .in_value     (s_tdata[FIELD_W-1:0]),
        .in_priority  (s_tdata[2*FIELD_W-1:FIELD_W]),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .res_status   (res_status),
        .res_value    (res_value),
        .res_priority (res_priority),
        .res_count    (res_count),
        .res_empty    (res_empty),
        .res_full     (res_full)
    );

    // Pack the result fields from the lowest bit up and pad to whole bytes.
    assign m_tdata = {6'd0, res_full, res_empty, res_count,
                      res_priority, res_value, res_status};

endmodule

// ----- hdl/smpq_ctrl.sv -----
// Controller of the sorted max-priority queue: handshakes and sequencing.
module smpq_ctrl
    import smpq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output smpq_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;
    logic fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // The update may run once the result register is free or drains now.
    assign fire     = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    assign cmd.capture = accept;
    assign cmd.execute = fire;
    assign m_tvalid    = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted transfer did not move the controller to execute");

    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("executed item produced no result");

endmodule

// ----- hdl/smpq_datapath.sv -----
// Datapath of the sorted max-priority queue: sorted cell row, count and result register.
module smpq_datapath
    import smpq_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  smpq_cmd_t                 cmd,
    input  logic                      in_mode,
    input  logic [FIELD_W-1:0]        in_value,
    input  logic [FIELD_W-1:0]        in_priority,
    input  logic                      cfg_we,
    input  logic [CAP_W-1:0]          cfg_wdata,
    output logic [STATUS_W-1:0]       res_status,
    output logic [FIELD_W-1:0]        res_value,
    output logic [FIELD_W-1:0]        res_priority,
    output logic [COUNT_OUT_W-1:0]    res_count,
    output logic                      res_empty,
    output logic                      res_full
);

    logic [DATA_WIDTH-1:0] val_reg  [DEPTH];
    logic [PRIO_WIDTH-1:0] prio_reg [DEPTH];
    logic [DATA_WIDTH-1:0] val_next [DEPTH];
    logic [PRIO_WIDTH-1:0] prio_next[DEPTH];
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CAP_W-1:0]      cap_reg;

    logic                  op_mode_reg;
    logic [DATA_WIDTH-1:0] op_value_reg;
    logic [PRIO_WIDTH-1:0] op_prio_reg;

    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [FIELD_W-1:0]     rval_reg, rval_next;
    logic [FIELD_W-1:0]     rprio_reg, rprio_next;
    logic [COUNT_OUT_W-1:0] rcount_reg;
    logic                   rempty_reg;
    logic                   rfull_reg;

    logic [CNT_W-1:0] eff_cap;
    logic [DEPTH-1:0] keep;
    logic [DEPTH-1:0] keep_prev;
    logic             update;

    // Capacity saturates at the number of cells.
    assign eff_cap = (32'(cap_reg) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_reg);

    // A cell keeps its entry on insert when it is occupied and its priority
    // is at least the new one; the row is sorted, so these cells form a prefix.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            keep[i] = (CNT_W'(i) < count_reg) &&
                      !($signed(prio_reg[i]) < $signed(op_prio_reg));
        end
        keep_prev[0] = 1'b1;
        for (int i = 1; i < DEPTH; i++) begin
            keep_prev[i] = keep[i-1];
        end
    end

    always_comb begin
        status_next = STATUS_DONE;
        rval_next   = '0;
        rprio_next  = '0;
        count_next  = count_reg;
        update      = 1'b0;
        if (op_mode_reg == MODE_ENQ) begin
            if (count_reg >= eff_cap) begin
                status_next = STATUS_OVERFLOW;
            end else begin
                update     = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            if (count_reg == '0) begin
                status_next = STATUS_UNDERFLOW;
            end else begin
                update     = 1'b1;
                count_next = count_reg - CNT_W'(1);
                rval_next  = FIELD_W'($signed(val_reg[0]));
                rprio_next = FIELD_W'($signed(prio_reg[0]));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            val_next[i]  = val_reg[i];
            prio_next[i] = prio_reg[i];
            if (op_mode_reg == MODE_ENQ) begin
                if (keep[i]) begin
                    val_next[i]  = val_reg[i];
                    prio_next[i] = prio_reg[i];
                end else if (keep_prev[i]) begin
                    val_next[i]  = op_value_reg;
                    prio_next[i] = op_prio_reg;
                end else if (i > 0) begin
                    val_next[i]  = val_reg[i-1];
                    prio_next[i] = prio_reg[i-1];
                end
            end else if (i < DEPTH - 1) begin
                val_next[i]  = val_reg[i+1];
                prio_next[i] = prio_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_mode_reg  <= in_mode;
            op_value_reg <= DATA_WIDTH'(in_value);
            op_prio_reg  <= PRIO_WIDTH'(in_priority);
        end
        if (cmd.execute) begin
            status_reg <= status_next;
            rval_reg   <= rval_next;
            rprio_reg  <= rprio_next;
            rcount_reg <= COUNT_OUT_W'(count_next);
            rempty_reg <= (count_next == '0);
            rfull_reg  <= (count_next >= eff_cap);
        end
        if (cmd.execute && update) begin
            for (int i = 0; i < DEPTH; i++) begin
                val_reg[i]  <= val_next[i];
                prio_reg[i] <= prio_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end else begin
            if (cmd.execute && update) begin
                count_reg <= count_next;
            end
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    assign res_status   = status_reg;
    assign res_value    = rval_reg;
    assign res_priority = rprio_reg;
    assign res_count    = rcount_reg;
    assign res_empty    = rempty_reg;
    assign res_full     = rfull_reg;

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(DEPTH))
        else $error("entry count exceeds the number of cells");

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> !($signed(prio_reg[0]) < $signed(prio_reg[1])))
        else $error("front entries out of priority order");

    a_dequeue_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.execute && op_mode_reg == MODE_DEQ && count_reg != '0)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("dequeue did not lower the count by one");

endmodule
